// ----- hdl/rpfc_pkg.sv -----
// Package for the RoCE/PFC packet classifier: field widths, class and error codes,
// ethertypes and counter indexes. It has no dependencies.
`default_nettype none
package rpfc_pkg;
  localparam int COUNTER_WIDTH = 64;
  localparam int LENGTH_WIDTH  = 16;
  localparam int NUM_COUNTERS  = 24;
  localparam int CIDX_W        = 5;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 128 + COUNTER_WIDTH;

  localparam logic [15:0] ETH_VLAN  = 16'h8100;
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_ARP   = 16'h0806;
  localparam logic [15:0] ETH_MACC  = 16'h8808;
  localparam logic [15:0] UDP_ROCE1 = 16'd4791;
  localparam logic [15:0] UDP_ROCE0 = 16'd4790;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [15:0] OP_PAUSE  = 16'h0001;
  localparam logic [15:0] OP_PFC    = 16'h0101;
  localparam logic [15:0] DEFAULT_RATE = 16'd1000;
  localparam logic [7:0]  NO_PRIORITY  = 8'hFF;

  localparam logic [2:0] CLS_ROCE  = 3'd0;
  localparam logic [2:0] CLS_UDP   = 3'd1;
  localparam logic [2:0] CLS_TCP   = 3'd2;
  localparam logic [2:0] CLS_ICMP  = 3'd3;
  localparam logic [2:0] CLS_ARP   = 3'd4;
  localparam logic [2:0] CLS_PAUSE = 3'd5;
  localparam logic [2:0] CLS_PFC   = 3'd6;
  localparam logic [2:0] CLS_ERROR = 3'd7;

  localparam logic [3:0] ERR_NONE  = 4'd0;
  localparam logic [3:0] ERR_SHORT = 4'd1;
  localparam logic [3:0] ERR_IP    = 4'd2;
  localparam logic [3:0] ERR_UDP   = 4'd3;
  localparam logic [3:0] ERR_PROTO = 4'd4;
  localparam logic [3:0] ERR_ETYPE = 4'd5;
  localparam logic [3:0] ERR_PFC   = 4'd6;
  localparam logic [3:0] ERR_RSHORT = 4'd7;
  localparam logic [3:0] ERR_BTH   = 4'd8;

  localparam int C_PKTS = 0,  C_BYTES = 1,  C_SHORT = 2,  C_IPERR = 3;
  localparam int C_IPPK = 4,  C_IPBY = 5,   C_UDPERR = 6, C_ROCEPK = 7;
  localparam int C_ROCEBY = 8, C_UDPPK = 9, C_UDPBY = 10, C_TCPPK = 11;
  localparam int C_TCPBY = 12, C_ICMPPK = 13, C_ICMPBY = 14, C_PROTERR = 15;
  localparam int C_ARPPK = 16, C_ARPBY = 17, C_PFCPK = 18, C_PFCBY = 19;
  localparam int C_PFCERR = 20, C_ETERR = 21, C_RSHORT = 22, C_BTHERR = 23;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;
endpackage
`default_nettype wire

// ----- hdl/roce_pfc_packet_classifier.sv -----
// Top level of the RoCE/PFC packet classifier: header capture, classification,
// statistics counters and the registered result stage. Depends on rpfc_pkg.
//
// Input beats carry either one frame byte (in_tuser low) or a counter read
// (in_tuser high). in_tlast marks the final captured byte of a frame; the
// on-wire length is taken with that beat. A frame's last byte and every
// counter read produce one result beat; other bytes produce none.
// The result is held in an output register from the cycle after the beat
// is taken. One beat is taken every cycle while the output register is empty
// or being drained; the header fields, the 24 counters and the sampling
// countdown all update at the edge that takes the beat, so a read right after
// a frame sees that frame counted.
// While out_tready is low with a result waiting, in_tready is low and the
// result holds. Reset clears the parse state, all counters and the output valid
// flag, and loads sample rate 1000 and its countdown. cfg_wr_en writes
// the sample rate (zero stores 1000) and reloads the countdown.
`default_nettype none
module roce_pfc_packet_classifier (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // data_byte [7:0], wire_length [23:8], counter_index [28:24], zero fill
  input  wire logic [rpfc_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                           in_tlast,
  // command
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // packet_class, error_code, source_port, destination_port, transport_opcode,
  // queue_pair, sequence_number, sampled, priority_mask, pause_quanta,
  // first_priority, counter_value
  output logic [rpfc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                           cfg_wr_en,
  input  wire logic [15:0]                    cfg_wr_data
);
  import rpfc_pkg::*;

  logic [LENGTH_WIDTH-1:0] pos_r;
  logic                    vlan_r, vlan_nxt;
  logic [15:0]             ftype_r, ftype_nxt;
  logic [7:0]              proto_r, proto_nxt;
  logic [6:0]              ihb_r, ihb_nxt;
  logic [31:0]             ports_r, ports_nxt;
  logic [55:0]             tf_r, tf_nxt;
  logic [39:0]             fc_r, fc_nxt;
  logic [15:0]             rate_r, pus_r;
  cnt_t                    cnt_r [NUM_COUNTERS];
  cnt_t                    cnt_add [NUM_COUNTERS];
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r, res_data;

  logic                    acc, is_read, is_last, first;
  logic [7:0]              b;
  logic [15:0]             wlen;
  logic [CIDX_W-1:0]       cidx;
  logic [LENGTH_WIDTH:0]   p, caplen, remain;
  logic [LENGTH_WIDTH:0]   ipoff, udp, bth, ihl, ihl_f, v, v_f;
  logic                    vb;
  logic [6:0]              ihb_b;
  logic [2:0]              cls;
  logic [3:0]              err;
  logic [15:0]             sp, dp, quanta;
  logic [7:0]              opc, mask, fpri;
  logic [23:0]             qp, psn;
  logic                    sampled;
  cnt_t                    cval;

  assign acc     = in_tvalid && in_tready;
  assign is_read = in_tuser;
  assign is_last = in_tlast;
  assign b       = in_tdata[7:0];
  assign wlen    = in_tdata[23:8];
  assign cidx    = in_tdata[28:24];
  assign first   = (pos_r == '0);
  assign in_tready = !out_valid_r || out_tready;

  // Header capture, built on the cleared registers at the first byte.
  always_comb begin
    vb    = first ? 1'b0 : vlan_r;
    ihb_b = first ? 7'd0 : ihb_r;
    vlan_nxt  = vb;
    ftype_nxt = first ? 16'd0 : ftype_r;
    proto_nxt = first ? 8'd0 : proto_r;
    ihb_nxt   = ihb_b;
    ports_nxt = first ? 32'd0 : ports_r;
    tf_nxt    = first ? 56'd0 : tf_r;
    fc_nxt    = first ? 40'd0 : fc_r;
    p     = {1'b0, pos_r};
    v     = vb ? (LENGTH_WIDTH+1)'(4) : '0;
    ihl   = (ihb_b < 7'd20) ? (LENGTH_WIDTH+1)'(20) : (LENGTH_WIDTH+1)'(ihb_b);
    ipoff = (LENGTH_WIDTH+1)'(14) + v;
    udp   = ipoff + ihl;
    bth   = udp + (LENGTH_WIDTH+1)'(8);
    if (p == (LENGTH_WIDTH+1)'(12) || p == (LENGTH_WIDTH+1)'(13)) begin
      ftype_nxt = {ftype_nxt[7:0], b};
      if (p == (LENGTH_WIDTH+1)'(13) && ftype_nxt == ETH_VLAN) vlan_nxt = 1'b1;
    end else if (vb && (p == (LENGTH_WIDTH+1)'(16) || p == (LENGTH_WIDTH+1)'(17))) begin
      ftype_nxt = {ftype_nxt[7:0], b};
    end
    if (p == ipoff) ihb_nxt = {1'b0, b[3:0], 2'b00};
    if (p == ipoff + (LENGTH_WIDTH+1)'(9)) proto_nxt = b;
    if (p >= udp && p < udp + (LENGTH_WIDTH+1)'(4)) ports_nxt = {ports_nxt[23:0], b};
    if (p == bth) tf_nxt[55:48] = b;
    if (p >= bth + (LENGTH_WIDTH+1)'(5) && p < bth + (LENGTH_WIDTH+1)'(8))
      tf_nxt[47:24] = {tf_nxt[39:24], b};
    if (p >= bth + (LENGTH_WIDTH+1)'(9) && p < bth + (LENGTH_WIDTH+1)'(12))
      tf_nxt[23:0] = {tf_nxt[15:0], b};
    if (p == ipoff || p == ipoff + (LENGTH_WIDTH+1)'(1))
      fc_nxt[39:24] = {fc_nxt[31:24], b};
    if (p == ipoff + (LENGTH_WIDTH+1)'(3)) fc_nxt[23:16] = b;
    if (p == ipoff + (LENGTH_WIDTH+1)'(4) || p == ipoff + (LENGTH_WIDTH+1)'(5))
      fc_nxt[15:0] = {fc_nxt[7:0], b};
  end

  // Classification at the last byte, on the freshly captured fields.
  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) cnt_add[i] = '0;
    caplen = p + (LENGTH_WIDTH+1)'(1);
    v_f    = vlan_nxt ? (LENGTH_WIDTH+1)'(4) : '0;
    ihl_f  = (ihb_nxt < 7'd20) ? (LENGTH_WIDTH+1)'(20) : (LENGTH_WIDTH+1)'(ihb_nxt);
    remain = caplen - ((LENGTH_WIDTH+1)'(14) + v_f);
    cls = CLS_ERROR; err = ERR_NONE;
    sp = '0; dp = '0; opc = '0; qp = '0; psn = '0;
    mask = '0; quanta = '0; fpri = NO_PRIORITY;
    cnt_add[C_PKTS]  = cnt_t'(1);
    cnt_add[C_BYTES] = cnt_t'(wlen);
    if (caplen < (LENGTH_WIDTH+1)'(14) || (vlan_nxt && caplen < (LENGTH_WIDTH+1)'(18))) begin
      err = ERR_SHORT; cnt_add[C_SHORT] = cnt_t'(1);
    end else if (ftype_nxt == ETH_IPV4) begin
      if (caplen < (LENGTH_WIDTH+1)'(34) + v_f) begin
        err = ERR_IP; cnt_add[C_IPERR] = cnt_t'(1);
      end else begin
        cnt_add[C_IPPK] = cnt_t'(1); cnt_add[C_IPBY] = cnt_t'(wlen);
        if (proto_nxt == PROTO_UDP) begin
          if (caplen < (LENGTH_WIDTH+1)'(22) + v_f + ihl_f) begin
            err = ERR_UDP; cnt_add[C_UDPERR] = cnt_t'(1);
          end else begin
            sp = ports_nxt[31:16]; dp = ports_nxt[15:0];
            if (sp == UDP_ROCE1 || sp == UDP_ROCE0 || dp == UDP_ROCE1 || dp == UDP_ROCE0) begin
              cnt_add[C_ROCEPK] = cnt_t'(1); cnt_add[C_ROCEBY] = cnt_t'(wlen);
              if (caplen < (LENGTH_WIDTH+1)'(54) + v_f) begin
                err = ERR_RSHORT; cnt_add[C_RSHORT] = cnt_t'(1);
              end else if (caplen < (LENGTH_WIDTH+1)'(34) + v_f + ihl_f) begin
                err = ERR_BTH; cnt_add[C_BTHERR] = cnt_t'(1);
              end else begin
                cls = CLS_ROCE;
                opc = tf_nxt[55:48]; qp = tf_nxt[47:24]; psn = tf_nxt[23:0];
              end
            end else begin
              cls = CLS_UDP; cnt_add[C_UDPPK] = cnt_t'(1); cnt_add[C_UDPBY] = cnt_t'(wlen);
            end
          end
        end else if (proto_nxt == PROTO_TCP) begin
          cls = CLS_TCP; cnt_add[C_TCPPK] = cnt_t'(1); cnt_add[C_TCPBY] = cnt_t'(wlen);
        end else if (proto_nxt == PROTO_ICMP) begin
          cls = CLS_ICMP; cnt_add[C_ICMPPK] = cnt_t'(1); cnt_add[C_ICMPBY] = cnt_t'(wlen);
        end else begin
          err = ERR_PROTO; cnt_add[C_PROTERR] = cnt_t'(1);
        end
      end
    end else if (ftype_nxt == ETH_ARP) begin
      cls = CLS_ARP; cnt_add[C_ARPPK] = cnt_t'(1); cnt_add[C_ARPBY] = cnt_t'(wlen);
    end else if (ftype_nxt == ETH_MACC) begin
      cnt_add[C_PFCPK] = cnt_t'(1); cnt_add[C_PFCBY] = cnt_t'(wlen);
      if (fc_nxt[39:24] == OP_PAUSE && remain >= (LENGTH_WIDTH+1)'(4)) begin
        cls = CLS_PAUSE;
      end else if (fc_nxt[39:24] == OP_PFC && remain >= (LENGTH_WIDTH+1)'(8)) begin
        cls = CLS_PFC;
        mask = fc_nxt[23:16]; quanta = fc_nxt[15:0];
        for (int k = 7; k >= 0; k--) if (mask[k]) fpri = 8'(k);
      end else begin
        err = ERR_PFC; cnt_add[C_PFCERR] = cnt_t'(1);
      end
    end else begin
      err = ERR_ETYPE; cnt_add[C_ETERR] = cnt_t'(1);
    end
    if (err != ERR_NONE) cls = CLS_ERROR;
    sampled = (pus_r <= 16'd1);
    cval = (cidx < CIDX_W'(NUM_COUNTERS)) ? cnt_r[cidx] : '0;
    if (is_read)
      res_data = {cval, NO_PRIORITY, 16'd0, 8'd0, 1'b0, 24'd0, 24'd0, 8'd0,
                  16'd0, 16'd0, ERR_NONE, 3'd0};
    else
      res_data = {cnt_t'(0), fpri, quanta, mask, sampled, psn, qp, opc, dp, sp, err, cls};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; vlan_r <= 1'b0; ftype_r <= '0; proto_r <= '0; ihb_r <= '0;
      ports_r <= '0; tf_r <= '0; fc_r <= '0;
      rate_r <= DEFAULT_RATE; pus_r <= DEFAULT_RATE;
      for (int i = 0; i < NUM_COUNTERS; i++) cnt_r[i] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rate_r <= (cfg_wr_data == 16'd0) ? DEFAULT_RATE : cfg_wr_data;
        pus_r  <= (cfg_wr_data == 16'd0) ? DEFAULT_RATE : cfg_wr_data;
      end else if (acc && !is_read && is_last) begin
        pus_r <= (pus_r <= 16'd1) ? rate_r : pus_r - 16'd1;
      end
      if (acc && !is_read) begin
        vlan_r <= vlan_nxt; ftype_r <= ftype_nxt; proto_r <= proto_nxt;
        ihb_r <= ihb_nxt; ports_r <= ports_nxt; tf_r <= tf_nxt; fc_r <= fc_nxt;
        if (is_last) begin
          pos_r <= '0;
          for (int i = 0; i < NUM_COUNTERS; i++) cnt_r[i] <= cnt_r[i] + cnt_add[i];
        end else if (pos_r != {LENGTH_WIDTH{1'b1}}) begin
          pos_r <= pos_r + LENGTH_WIDTH'(1);
        end
      end
      if (acc && (is_read || is_last)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    if (acc && (is_read || is_last)) out_data_r <= res_data;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (is_read || is_last) |=> out_valid_r) else $error("result beat lost");
  a_posclr: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !is_read && is_last && !cfg_wr_en |=> pos_r == '0) else $error("position not cleared");
  a_pus: assert property (@(posedge clk) disable iff (!rst_n)
    pus_r != 16'd0) else $error("sample countdown at zero");
  a_pri: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[127:120] != NO_PRIORITY |-> out_data_r[2:0] == CLS_PFC)
    else $error("priority reported outside PFC");
endmodule
`default_nettype wire
